// File: design/mvd_pkg.sv
// Shared types and constants for the masked vector distance block.
// Holds metric and register codes and the control/status structs.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package mvd_pkg;

  // Field widths fixed by the interface.
  localparam int DATA_W          = 32;
  localparam int DIST_W          = 48;
  localparam int USED_W          = 13;
  localparam int FRAC_W          = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 3;
  localparam int MAX_COLUMNS_DEF = 4096;

  // A Canberra term is at most 1.0 in Q.16, so it needs 17 quotient bits.
  localparam int CB_TERM_W  = 17;
  // The root of a 64-bit value times 2^16 has 40 bits, one per step.
  localparam int SQRT_STEPS = 40;

  typedef enum logic [2:0] {
    METRIC_EUCLID  = 3'd0,
    METRIC_MANHAT  = 3'd1,
    METRIC_CHEBY   = 3'd2,
    METRIC_HAMMING = 3'd3,
    METRIC_CANB    = 3'd4,
    METRIC_BRAY    = 3'd5
  } metric_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METRIC = 2'd0,
    CFG_IGNORE = 2'd1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic cb_start;
    logic acc;
    logic fin;
    logic mul_step;
    logic div_start;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } mvd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic take;
    logic last;
    logic fin_undef;
    logic use_mul;
    logic use_div;
    logic use_sqrt;
    logic div_busy;
    logic out_free;
  } mvd_status_t;

endpackage

// File: design/mvd_div.sv
// Restoring divider, one quotient bit per cycle.
// Used for Canberra terms and for the final rescale and ratio divisions.
// Depends on mvd_pkg.
`timescale 1ns / 1ps

module mvd_div
  import mvd_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = 46,
  parameter int SW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW:0]   rem0_i,
  input  logic [NW-1:0] num0_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] steps_i,
  output logic          busy_o,
  output logic [NW:0]   quo_o
);

  logic [DW:0]   rem_q, rem_d;
  logic [NW-1:0] num_q;
  logic [NW:0]   quo_q;
  logic [DW-1:0] den_q;
  logic [SW-1:0] cnt_q;
  logic          busy_q;
  logic          ge;
  logic [DW:0]   diff;

  // Compare and subtract, then shift the next dividend bit in.
  always_comb begin
    ge    = rem_q >= {1'b0, den_q};
    diff  = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    rem_d = {diff[DW-1:0], num_q[NW-1]};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == SW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem0_i;
      num_q <= num0_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[NW-2:0], 1'b0};
      quo_q <= {quo_q[NW-1:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: design/mvd_datapath.sv
// Datapath: input capture, per-column sums, final multiply, divide and root.
// Holds the configuration registers and the result register.
// Depends on mvd_pkg and mvd_div.
`timescale 1ns / 1ps

module mvd_datapath
  import mvd_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mvd_cmd_t                cmd_i,
  output mvd_status_t             status_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic signed [DATA_W-1:0] a_value_i,
  input  logic signed [DATA_W-1:0] b_value_i,
  input  logic                    a_present_i,
  input  logic                    b_present_i,
  input  logic                    last_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [DIST_W-1:0]       distance_o,
  output logic                    undefined_o,
  output logic [USED_W-1:0]       used_columns_o,
  output logic                    too_long_o
);

  localparam int CW  = $clog2(MAX_COLUMNS + 2);
  localparam int ADW = DATA_W + CW;
  localparam int SQW = 2 * DATA_W - FRAC_W + CW;
  localparam int CBW = CB_TERM_W + CW;
  localparam int MGW = DATA_W + 1 + CW;
  localparam int NW  = (SQW + CW > 64) ? (SQW + CW) : 64;
  localparam int DW  = MGW;
  localparam int SW  = $clog2(NW + 2);
  localparam int RTW = SQRT_STEPS;
  localparam int RMW = RTW + 3;

  // Configuration registers.
  logic [2:0] metric_q;
  logic       ignore_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_EUCLID;
      ignore_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_METRIC: metric_q <= cfg_data_i[2:0];
        CFG_IGNORE: ignore_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Captured column and its derived values.
  logic signed [DATA_W-1:0] a_q, b_q;
  logic                     pres_q, last_q;
  logic [DATA_W-1:0]        d_q;
  logic [DATA_W:0]          mag_q;
  logic [2*DATA_W-FRAC_W-1:0] sq_q;

  logic signed [DATA_W:0] ax, bx, diff;
  logic [DATA_W-1:0]      d_c, aabs, babs;
  logic [2*DATA_W-1:0]    sq_full;

  always_comb begin
    ax      = {a_q[DATA_W-1], a_q};
    bx      = {b_q[DATA_W-1], b_q};
    diff    = ax - bx;
    d_c     = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    aabs    = a_q[DATA_W-1] ? DATA_W'(-ax) : DATA_W'(ax);
    babs    = b_q[DATA_W-1] ? DATA_W'(-bx) : DATA_W'(bx);
    sq_full = d_q * d_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q <= a_value_i;
      b_q <= b_value_i;
    end
    if (cmd_i.prep) begin
      d_q   <= d_c;
      mag_q <= {1'b0, aabs} + {1'b0, babs};
    end
    if (cmd_i.cb_start) begin
      sq_q <= sq_full[2*DATA_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q <= 1'b0;
      last_q <= 1'b0;
    end else if (cmd_i.capture) begin
      pres_q <= a_present_i & b_present_i;
      last_q <= last_i;
    end
  end

  // Divider shared by the Canberra terms and the final division.
  logic [NW-1:0] prod_q, mcand_q;
  logic [CW-1:0] mplier_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   div_rem0;
  logic [NW-1:0] div_num0;
  logic [DW-1:0] div_den;
  logic [SW-1:0] div_steps;
  logic          div_busy;
  logic [NW:0]   quo;

  always_comb begin
    if (cmd_i.cb_start) begin
      div_rem0  = (DW + 1)'(d_q);
      div_num0  = '0;
      div_den   = DW'(mag_q);
      div_steps = SW'(CB_TERM_W);
    end else begin
      div_rem0  = '0;
      div_num0  = prod_q;
      div_den   = den_q;
      div_steps = SW'(NW + 1);
    end
  end

  mvd_div #(
    .NW(NW),
    .DW(DW),
    .SW(SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cb_start | cmd_i.div_start),
    .rem0_i (div_rem0),
    .num0_i (div_num0),
    .den_i  (div_den),
    .steps_i(div_steps),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  // Row accumulators.
  logic [CW-1:0]     total_q, used_q, unequal_q;
  logic [ADW-1:0]    abs_q;
  logic [SQW-1:0]    sqs_q;
  logic [DATA_W-1:0] max_q;
  logic [CBW-1:0]    canb_q;
  logic [MGW-1:0]    magsum_q;
  logic              miss_q;
  logic              in_range;

  assign in_range = total_q < CW'(MAX_COLUMNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      used_q    <= '0;
      unequal_q <= '0;
      abs_q     <= '0;
      sqs_q     <= '0;
      max_q     <= '0;
      canb_q    <= '0;
      magsum_q  <= '0;
      miss_q    <= 1'b0;
    end else if (cmd_i.out_load) begin
      total_q   <= '0;
      used_q    <= '0;
      unequal_q <= '0;
      abs_q     <= '0;
      sqs_q     <= '0;
      max_q     <= '0;
      canb_q    <= '0;
      magsum_q  <= '0;
      miss_q    <= 1'b0;
    end else if (cmd_i.acc) begin
      if (in_range) begin
        if (pres_q) begin
          used_q   <= used_q + 1'b1;
          abs_q    <= abs_q + ADW'(d_q);
          sqs_q    <= sqs_q + SQW'(sq_q);
          magsum_q <= magsum_q + MGW'(mag_q);
          if (d_q > max_q) begin
            max_q <= d_q;
          end
          if (d_q != '0) begin
            unequal_q <= unequal_q + 1'b1;
          end
          if (mag_q != '0) begin
            canb_q <= canb_q + CBW'(quo[CB_TERM_W-1:0]);
          end
        end else begin
          miss_q <= 1'b1;
        end
      end
      if (total_q <= CW'(MAX_COLUMNS)) begin
        total_q <= total_q + 1'b1;
      end
    end
  end

  // Final decisions on the row.
  logic fin_undef, rescale, too_long;

  always_comb begin
    too_long  = total_q > CW'(MAX_COLUMNS);
    fin_undef = too_long || (used_q == '0) || (miss_q && !ignore_q) ||
                (metric_q > METRIC_BRAY) ||
                ((metric_q == METRIC_BRAY) && (magsum_q == '0));
    rescale   = ignore_q && (used_q != total_q);
  end

  // Final operand setup and shift-and-add multiply by the column ratio.
  logic undef_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      undef_q  <= fin_undef;
      prod_q   <= '0;
      mplier_q <= rescale ? total_q : CW'(1);
      den_q    <= rescale ? DW'(used_q) : DW'(1);
      priority case (metric_q)
        METRIC_EUCLID: mcand_q <= NW'(sqs_q);
        METRIC_CANB:   mcand_q <= NW'(canb_q);
        default:       mcand_q <= NW'(abs_q);
      endcase
      if (metric_q == METRIC_HAMMING) begin
        prod_q <= NW'(unequal_q) << FRAC_W;
        den_q  <= DW'(used_q);
      end else if (metric_q == METRIC_BRAY) begin
        prod_q <= NW'(abs_q) << FRAC_W;
        den_q  <= magsum_q;
      end
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  // Square root by the digit method, two radicand bits per step.
  logic [RTW+FRAC_W*2+8-1:0] sx_q;
  logic [RMW-1:0]            rem_q, rem_sh, trial;
  logic [RTW-1:0]            root_q;
  logic [63:0]               q_sat64;

  always_comb begin
    q_sat64 = (|quo[NW:64]) ? '1 : quo[63:0];
    rem_sh  = {rem_q[RMW-3:0], sx_q[$bits(sx_q)-1 -: 2]};
    trial   = RMW'({root_q, 2'b01});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_load) begin
      sx_q   <= {q_sat64, {FRAC_W{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sx_q <= sx_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RTW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RTW-2:0], 1'b0};
      end
    end
  end

  // Result register and its valid flag.
  logic [DIST_W-1:0] dist_c;
  logic              out_valid_q;

  always_comb begin
    if (undef_q) begin
      dist_c = '0;
    end else if (metric_q == METRIC_CHEBY) begin
      dist_c = DIST_W'(max_q);
    end else if (metric_q == METRIC_EUCLID) begin
      dist_c = DIST_W'(root_q);
    end else begin
      dist_c = (|quo[NW:DIST_W]) ? '1 : quo[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      distance_o     <= dist_c;
      undefined_o    <= undef_q;
      used_columns_o <= USED_W'(used_q);
      too_long_o     <= too_long;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status toward the controller.
  always_comb begin
    status_o.take      = pres_q && in_range;
    status_o.last      = last_q;
    status_o.fin_undef = fin_undef;
    status_o.use_mul   = (metric_q == METRIC_EUCLID) || (metric_q == METRIC_MANHAT) ||
                         (metric_q == METRIC_CANB);
    status_o.use_div   = metric_q != METRIC_CHEBY;
    status_o.use_sqrt  = metric_q == METRIC_EUCLID;
    status_o.div_busy  = div_busy;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

// File: design/mvd_ctrl.sv
// Controller state machine sequencing column updates and the row result.
// Drives commands to the datapath and the input stall.
// Depends on mvd_pkg.
`timescale 1ns / 1ps

module mvd_ctrl
  import mvd_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  mvd_status_t status_i,
  output mvd_cmd_t    cmd_o
);

  localparam int CW   = $clog2(MAX_COLUMNS + 2);
  localparam int CNTW = $clog2(((CW > SQRT_STEPS) ? CW : SQRT_STEPS) + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CB,
    ST_CBW,
    ST_ACC,
    ST_FIN,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_SQL,
    ST_SQ,
    ST_OUT
  } state_e;

  state_e          state_q;
  logic [CNTW-1:0] cnt_q;
  logic            stall_q;
  logic            accept;

  assign accept     = in_valid_i && !stall_q;
  assign in_stall_o = stall_q;

  // State, step counter and the registered stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_PREP;
            stall_q <= 1'b1;
          end
        end
        ST_PREP: state_q <= status_i.take ? ST_CB : ST_ACC;
        ST_CB:   state_q <= ST_CBW;
        ST_CBW: begin
          if (!status_i.div_busy) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (status_i.last) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        ST_FIN: begin
          if (status_i.fin_undef || !status_i.use_div) begin
            state_q <= ST_OUT;
          end else if (status_i.use_mul) begin
            state_q <= ST_MUL;
            cnt_q   <= CNTW'(CW);
          end else begin
            state_q <= ST_DIVS;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) begin
            state_q <= ST_DIVS;
          end
        end
        ST_DIVS: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (!status_i.div_busy) begin
            state_q <= status_i.use_sqrt ? ST_SQL : ST_OUT;
          end
        end
        ST_SQL: begin
          state_q <= ST_SQ;
          cnt_q   <= CNTW'(SQRT_STEPS);
        end
        ST_SQ: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode from the current state, the input handshake and the output space.
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.prep      = state_q == ST_PREP;
    cmd_o.cb_start  = state_q == ST_CB;
    cmd_o.acc       = state_q == ST_ACC;
    cmd_o.fin       = state_q == ST_FIN;
    cmd_o.mul_step  = state_q == ST_MUL;
    cmd_o.div_start = state_q == ST_DIVS;
    cmd_o.sqrt_load = state_q == ST_SQL;
    cmd_o.sqrt_step = state_q == ST_SQ;
    cmd_o.out_load  = (state_q == ST_OUT) && status_i.out_free;
  end

endmodule

// File: design/masked_vector_distance.sv
// Top level of the masked vector distance block.
// Joins the controller and the datapath; depends on mvd_pkg, mvd_ctrl, mvd_datapath.
//
//   Channel   Handshake            Payload
//   input     in_valid_i/stall_o   a_value, b_value, a_present, b_present, last
//   output    out_valid_o/stall_i  distance, undefined, used_columns, too_long
//   config    cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// A column passes through the idle, prep and accumulate states when missing or
// out of range. A used column also runs its Canberra term through the shared
// restoring divider in 17 steps, after a start state, in a state that waits for
// the divider to finish. The last column then sets up the result; an undefined
// row goes straight to output. Otherwise Euclidean, Manhattan and Canberra
// multiply by the column ratio, and every metric except Chebyshev divides: a
// start state, then a wait for 75 quotient steps at the default column limit.
// Euclidean then adds a square root. The output state waits while the previous
// result is stalled. Reset clears all sums at once.
// A waiting result does not stop the next row until that row's last column.
`timescale 1ns / 1ps

module masked_vector_distance
  import mvd_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DATA_W-1:0] a_value_i,
  input  logic signed [DATA_W-1:0] b_value_i,
  input  logic                    a_present_i,
  input  logic                    b_present_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DIST_W-1:0]       distance_o,
  output logic                    undefined_o,
  output logic [USED_W-1:0]       used_columns_o,
  output logic                    too_long_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  mvd_cmd_t    cmd;
  mvd_status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  mvd_ctrl #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mvd_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .a_value_i     (a_value_i),
    .b_value_i     (b_value_i),
    .a_present_i   (a_present_i),
    .b_present_i   (b_present_i),
    .last_i        (last_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .distance_o    (distance_o),
    .undefined_o   (undefined_o),
    .used_columns_o(used_columns_o),
    .too_long_o    (too_long_o)
  );

endmodule
